FILE: hw/rtl/tts_pkg.sv
// Package for the task timer scheduler: table size, codes and the packed
// command, result and slot types used by the deadline unit and the top level.
// No dependencies.
package tts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FIND  = 2'd1,
        S_SHIFT = 2'd2,
        S_TICK  = 2'd3
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  task_id;
        logic [31:0] now_time;
        logic [31:0] delay_ticks;
        logic        periodic;
        logic        halted;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [7:0]  fired_id;
        logic [3:0]  fired_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] start;
        logic [31:0] delay;
        logic        periodic;
        logic        halted;
    } slot_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        slot_t            data;
    } slot_wr_t;

endpackage

FILE: hw/rtl/tts_slot_file.sv
// Generic RAM: one write port and one registered read port.
// No dependencies.
module tts_slot_file #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tts_due_unit.sv
// Shared deadline unit: wrap-aware due test and the start time after firing.
// Depends on tts_pkg.
module tts_due_unit
    import tts_pkg::*;
(
    input  slot_t       slot,
    input  logic [31:0] now_time,
    output logic        due,
    output logic [31:0] new_start
);

    logic [31:0] next_time;
    logic        past_next;
    logic        before_start;

    always_comb
    begin
        next_time    = slot.start + slot.delay;
        past_next    = now_time >= next_time;
        before_start = now_time < slot.start;
        due          = ((next_time >= slot.start) && (past_next || before_start)) ||
                       (past_next && before_start);
        new_start    = slot.periodic ? next_time : now_time;
    end

endmodule

FILE: hw/rtl/task_timer_scheduler_top.sv
// Task timer scheduler top level: command sequencer, task table and the
// shared deadline unit. Depends on tts_pkg, tts_slot_file, tts_due_unit.
//
// A command is taken when start is high and busy is low. Every result shows
// on result for one cycle with strobe high and cannot be held off; the final
// result of a command has last set. The sequencer visits one table slot per
// cycle through the single read port and the shared deadline unit. A tick
// gives one fired item per due task that is not halted, in table order, then
// the tick-finished item. An update or a remove searches the table from slot
// 0 and answers not-found on a miss; after its match a remove shifts the
// later slots down by one place.
module task_timer_scheduler_top
    import tts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    strobe,
    output result_t result
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [3:0]       fired_reg, fired_next;
    logic             strobe_reg, strobe_next;
    result_t          result_reg, result_next;
    cmd_t             cmd_reg;

    slot_wr_t         wr;
    logic [IDX_W-1:0] rd_addr;
    slot_t            rd_data;
    logic [CNT_W-1:0] idx_plus;
    logic [CNT_W-1:0] rd_next_plus;
    logic             due;
    logic [31:0]      new_start;
    logic             accept;

    tts_slot_file #(
        .WIDTH  ($bits(slot_t)),
        .DEPTH  (MAX_TASKS),
        .ADDR_W (IDX_W)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tts_due_unit u_due (
        .slot      (rd_data),
        .now_time  (cmd_reg.now_time),
        .due       (due),
        .new_start (new_start)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign idx_plus     = idx_reg + CNT_W'(1);
    assign rd_next_plus = idx_next + CNT_W'(1);
    assign rd_addr      = (state_next == S_SHIFT) ? rd_next_plus[IDX_W-1:0]
                                                  : idx_next[IDX_W-1:0];
    assign strobe       = strobe_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            fired_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            fired_reg  <= fired_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        fired_next  = fired_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        wr.en       = 1'b0;
        wr.addr     = idx_reg[IDX_W-1:0];
        wr.data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    fired_next = '0;
                    unique case (cmd.op)
                        OP_ADD:
                        begin
                            strobe_next = 1'b1;
                            result_next = '{KIND_STATUS, STAT_OK, cmd.task_id, 4'd0, 1'b1};
                            if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                result_next.status = STAT_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = count_reg[IDX_W-1:0];
                                wr.data    = '{cmd.task_id, cmd.now_time, cmd.delay_ticks,
                                               cmd.periodic, cmd.halted};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            state_next = S_FIND;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (idx_reg >= count_reg)
                begin
                    strobe_next = 1'b1;
                    result_next = '{KIND_STATUS, STAT_NOT_FOUND, cmd_reg.task_id, 4'd0, 1'b1};
                    state_next  = S_IDLE;
                end
                else if (rd_data.id == cmd_reg.task_id)
                begin
                    if (cmd_reg.op == OP_UPDATE)
                    begin
                        wr.en         = 1'b1;
                        wr.data.delay = cmd_reg.delay_ticks;
                        wr.data.halted = cmd_reg.halted;
                        strobe_next   = 1'b1;
                        result_next   = '{KIND_STATUS, STAT_OK, cmd_reg.task_id, 4'd0, 1'b1};
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end
            S_SHIFT:
            begin
                if (idx_plus < count_reg)
                begin
                    wr.en    = 1'b1;
                    idx_next = idx_plus;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    strobe_next = 1'b1;
                    result_next = '{KIND_STATUS, STAT_OK, cmd_reg.task_id, 4'd0, 1'b1};
                    state_next  = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (idx_reg >= count_reg)
                begin
                    strobe_next = 1'b1;
                    result_next = '{KIND_DONE, STAT_OK, 8'd0, fired_reg, 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_plus;
                    if (!rd_data.halted && due)
                    begin
                        wr.en         = 1'b1;
                        wr.data.start = new_start;
                        fired_next    = fired_reg + 4'd1;
                        strobe_next   = 1'b1;
                        result_next   = '{KIND_FIRED, STAT_OK, rd_data.id, 4'd0, 1'b0};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_idle_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && strobe) |-> result.last)
        else $error("result while idle is not the final one");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_ADD) |=> (strobe && result.last && !busy))
        else $error("add did not reply in one cycle");

    a_fired_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.kind == KIND_FIRED) |-> (busy && !result.last))
        else $error("fired item outside a tick scan");
`endif

endmodule

FILE: test/tb_task_timer_scheduler_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for task_timer_scheduler_top: directed and random
// add, remove, tick and update transfers, checked against a task table model.
// Depends on tts_pkg and the scheduler RTL.
module tb_task_timer_scheduler_top;
    import tts_pkg::*;

    localparam int RANDOM_ITEMS = 155;
    localparam int STEADY_TAIL  = 30;

    class timer_table;
        slot_t       slots [MAX_TASKS];
        int unsigned task_count;
        result_t     expected_results [$];
        int unsigned error_count;

        function new();
            task_count  = 0;
            error_count = 0;
        endfunction

        function bit deadline_passed(logic [31:0] t_start, logic [31:0] t_delay,
                                     logic [31:0] t_now);
            logic [31:0] t_next;
            t_next = t_start + t_delay;
            return ((t_next >= t_start) && ((t_now >= t_next) || (t_now < t_start))) ||
                   ((t_now >= t_next) && (t_now < t_start));
        endfunction

        function int find_slot(logic [7:0] id);
            for (int i = 0; i < task_count; i++)
            begin
                if (slots[i].id == id)
                    return i;
            end
            return -1;
        endfunction

        function void push_result(kind_t k, status_t st, logic [7:0] id,
                                  logic [3:0] cnt, logic lst);
            result_t r;
            r.kind        = k;
            r.status      = st;
            r.fired_id    = id;
            r.fired_count = cnt;
            r.last        = lst;
            expected_results.push_back(r);
        endfunction

        function void take_command(cmd_t c);
            int         pos;
            logic [3:0] fired;
            case (c.op)
                OP_ADD:
                begin
                    if (task_count >= MAX_TASKS)
                        push_result(KIND_STATUS, STAT_FULL, c.task_id, 4'd0, 1'b1);
                    else
                    begin
                        slots[task_count].id       = c.task_id;
                        slots[task_count].start    = c.now_time;
                        slots[task_count].delay    = c.delay_ticks;
                        slots[task_count].periodic = c.periodic;
                        slots[task_count].halted   = c.halted;
                        task_count++;
                        push_result(KIND_STATUS, STAT_OK, c.task_id, 4'd0, 1'b1);
                    end
                end
                OP_REMOVE:
                begin
                    pos = find_slot(c.task_id);
                    if (pos < 0)
                        push_result(KIND_STATUS, STAT_NOT_FOUND, c.task_id, 4'd0, 1'b1);
                    else
                    begin
                        for (int i = pos; i + 1 < task_count; i++)
                            slots[i] = slots[i + 1];
                        task_count--;
                        push_result(KIND_STATUS, STAT_OK, c.task_id, 4'd0, 1'b1);
                    end
                end
                OP_UPDATE:
                begin
                    pos = find_slot(c.task_id);
                    if (pos < 0)
                        push_result(KIND_STATUS, STAT_NOT_FOUND, c.task_id, 4'd0, 1'b1);
                    else
                    begin
                        slots[pos].delay  = c.delay_ticks;
                        slots[pos].halted = c.halted;
                        push_result(KIND_STATUS, STAT_OK, c.task_id, 4'd0, 1'b1);
                    end
                end
                OP_TICK:
                begin
                    fired = 4'd0;
                    for (int i = 0; i < task_count; i++)
                    begin
                        if (!slots[i].halted &&
                            deadline_passed(slots[i].start, slots[i].delay, c.now_time))
                        begin
                            push_result(KIND_FIRED, STAT_OK, slots[i].id, 4'd0, 1'b0);
                            fired++;
                            if (slots[i].periodic)
                                slots[i].start = slots[i].start + slots[i].delay;
                            else
                                slots[i].start = c.now_time;
                        end
                    end
                    push_result(KIND_DONE, STAT_OK, 8'd0, fired, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t: %s mismatch: expected %0h actual %0h",
                         $time, name, exp_val, act_val);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual %p", $time, got);
                error_count++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("kind", exp.kind, got.kind);
            compare_field("status", exp.status, got.status);
            compare_field("fired_id", exp.fired_id, got.fired_id);
            compare_field("fired_count", exp.fired_count, got.fired_count);
            compare_field("last", exp.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        strobe;
    result_t     result;

    timer_table  timers;
    logic [31:0] sched_now;
    cmd_t        directed [$];

    task_timer_scheduler_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            timers.check_result(result);
    end

    function automatic cmd_t make_cmd(op_t op, logic [7:0] id, logic [31:0] t_now,
                                      logic [31:0] t_delay, logic per, logic halt);
        cmd_t c;
        c.op          = op;
        c.task_id     = id;
        c.now_time    = t_now;
        c.delay_ticks = t_delay;
        c.periodic    = per;
        c.halted      = halt;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < ((timers.task_count >= MAX_TASKS) ? 8 : 35))
            c.op = OP_ADD;
        else if (pick < 65)
            c.op = OP_TICK;
        else if (pick < 82)
            c.op = OP_REMOVE;
        else
            c.op = OP_UPDATE;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.task_id = $urandom_range(0, 255);
        else if (pick < 3 || timers.task_count == 0)
            c.task_id = $urandom_range(0, 15);
        else
            c.task_id = timers.slots[$urandom_range(0, timers.task_count - 1)].id;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            sched_now = $urandom();
        else if (pick == 1)
            sched_now = 32'hFFFF_FFE0 + $urandom_range(0, 31);
        else
            sched_now = sched_now + $urandom_range(0, 40);
        c.now_time = sched_now;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            c.delay_ticks = '0;
        else if (pick < 6)
            c.delay_ticks = $urandom();
        else
            c.delay_ticks = $urandom_range(1, 60);
        c.periodic = $urandom_range(0, 1);
        c.halted   = ($urandom_range(0, 4) == 0);
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        timers.take_command(c);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 3))
            @(posedge clk);
    endtask

    initial
    begin
        int drain;
        timers    = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        sched_now = '0;

        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_REMOVE, 8'd5, '1, '1, 1'b1, 1'b1));
        directed.push_back(make_cmd(OP_UPDATE, 8'd5, 32'd0, 32'd7, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'h80, 32'd0, 32'd0, 1'b0, 1'b1));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'd123, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_REMOVE, 8'h80, 32'd0, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'd0, 32'd0, 32'd0, 1'b1, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'hFF, '1, '1, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'd7, 32'hFFFF_FFF0, 32'd32, 1'b1, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'd7, 32'd100, 32'd10, 1'b0, 1'b1));
        directed.push_back(make_cmd(OP_ADD, 8'd9, 32'd50, 32'd20, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'd5, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'h10, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'hFFFF_FFFE, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_UPDATE, 8'd7, 32'd0, 32'd0, 1'b0, 1'b1));
        directed.push_back(make_cmd(OP_ADD, 8'hAA, 32'd1000, 32'd1, 1'b1, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'h55, 32'd2000, 32'd2, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'h11, 32'd3000, 32'd3, 1'b1, 1'b0));
        directed.push_back(make_cmd(OP_ADD, 8'hFF, 32'd4000, 32'd4, 1'b1, 1'b1));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'd3000, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_UPDATE, 8'd7, 32'd0, 32'd5, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_REMOVE, 8'd7, 32'd0, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_REMOVE, 8'h11, 32'd0, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_REMOVE, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_TICK, 8'd0, '1, 32'd0, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_UPDATE, 8'd9, 32'd0, '1, 1'b0, 1'b0));
        directed.push_back(make_cmd(OP_TICK, 8'd0, 32'h8000_0000, 32'd0, 1'b0, 1'b0));

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_cmd(directed[i]);
            if ($urandom_range(0, 2) == 0)
                idle_burst();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_cmd(random_cmd());
            if (n < RANDOM_ITEMS - STEADY_TAIL && $urandom_range(0, 2) == 0)
                idle_burst();
        end
        start <= 1'b0;

        drain = 0;
        while (timers.expected_results.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (30)
            @(posedge clk);

        if (timers.expected_results.size() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, timers.expected_results.size());
        if (timers.error_count == 0 && timers.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tts_pkg.sv
hw/rtl/tts_slot_file.sv
hw/rtl/tts_due_unit.sv
hw/rtl/task_timer_scheduler_top.sv
test/tb_task_timer_scheduler_top.sv
